// ===== hdl/ttce_pkg.sv =====
package ttce_pkg;

    // Terminal geometry.
    localparam int DISPLAY_COLS = 80;
    localparam int DISPLAY_ROWS = 25;
    localparam int BUFFER_ROWS  = 64;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 7;
    localparam int HDR_W  = 5;
    localparam int ATTR_W = 8;
    localparam int CHAR_W = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET    = 8'd7;
    localparam logic [HDR_W-1:0]  HEADER_LINES_RESET = 5'd1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_ATTR    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_LINES = 1'b1;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    typedef enum logic [1:0] {
        OP_PUT        = 2'd0,
        OP_PAGE_UP    = 2'd1,
        OP_PAGE_DOWN  = 2'd2,
        OP_SET_CURSOR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] char_code;
        logic              final_char;
        logic [6:0]        new_row;
        logic [7:0]        new_col;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] view;
        logic [ROW_W-1:0] top;
        logic             pend;
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic [ROW_W-1:0]  cell_line;
        logic [COL_W-1:0]  cell_column;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  first_visible;
        logic [ROW_W-1:0]  top_line;
        logic              redraw;
        logic              last;
    } t_result;

    typedef struct packed {
        t_result first;
        t_result second;
        logic    has_second;
    } t_step_out;

endpackage

// ===== hdl/ttce_step.sv =====
module ttce_step (
    input  ttce_pkg::t_state                    i_state,
    input  ttce_pkg::t_item                     i_item,
    input  logic [ttce_pkg::ATTR_W-1:0]         i_text_attr,
    input  logic [ttce_pkg::HDR_W-1:0]          i_header_lines,
    output ttce_pkg::t_state                    o_state,
    output ttce_pkg::t_step_out                 o_out
);

    logic [6:0] vis;
    logic [6:0] lines;
    logic [6:0] limit;
    logic [6:0] vsum;
    logic [6:0] row_x;
    logic [6:0] col_x;
    logic [6:0] view_x;
    logic [6:0] wsum;
    logic [3:0] tab_grp;
    logic [ttce_pkg::ROW_W-1:0] top_n;
    logic [ttce_pkg::ROW_W-1:0] wline;
    logic [ttce_pkg::ROW_W-1:0] cline;
    logic [ttce_pkg::COL_W-1:0] wcol;
    logic wrote;
    logic cleared;
    logic redraw;
    ttce_pkg::t_state  nxt;
    ttce_pkg::t_result base;
    ttce_pkg::t_result r0;
    ttce_pkg::t_result r1;
    logic has_second;

    always_comb begin
        nxt     = i_state;
        wrote   = 1'b0;
        cleared = 1'b0;
        redraw  = 1'b0;
        wline   = '0;
        wcol    = '0;
        cline   = '0;
        vsum    = '0;
        tab_grp = '0;
        top_n   = i_state.top;
        row_x   = {1'b0, i_state.row};
        col_x   = i_state.col;
        view_x  = {1'b0, i_state.view};
        wsum    = {1'b0, i_state.top} + {1'b0, i_state.row};

        // A header taller than the screen still leaves one text row.
        if (i_header_lines > 5'(ttce_pkg::DISPLAY_ROWS - 1)) begin
            vis = 7'd1;
        end else begin
            vis = 7'(ttce_pkg::DISPLAY_ROWS) - {2'b00, i_header_lines};
        end
        lines = vis - 7'd1;
        limit = (7'(ttce_pkg::BUFFER_ROWS) > vis) ? 7'(ttce_pkg::BUFFER_ROWS) - vis : 7'd0;

        case (i_item.op)
            ttce_pkg::OP_PAGE_UP: begin
                if (lines > view_x) begin
                    nxt.view = '0;
                end else begin
                    nxt.view = i_state.view - lines[5:0];
                end
                redraw = 1'b1;
            end
            ttce_pkg::OP_PAGE_DOWN: begin
                vsum = view_x + lines;
                nxt.view = (vsum > limit) ? limit[5:0] : vsum[5:0];
                redraw = 1'b1;
            end
            ttce_pkg::OP_SET_CURSOR: begin
                nxt.row = (i_item.new_row > 7'(ttce_pkg::BUFFER_ROWS - 1))
                          ? 6'(ttce_pkg::BUFFER_ROWS - 1) : i_item.new_row[5:0];
                nxt.col = (i_item.new_col > 8'(ttce_pkg::DISPLAY_COLS - 1))
                          ? 7'(ttce_pkg::DISPLAY_COLS - 1) : i_item.new_col[6:0];
            end
            default: begin
                case (i_item.char_code)
                    ttce_pkg::CH_NEWLINE: begin
                        col_x = '0;
                        row_x = row_x + 7'd1;
                    end
                    ttce_pkg::CH_RETURN: begin
                        col_x = '0;
                    end
                    ttce_pkg::CH_TAB: begin
                        tab_grp = col_x[6:3] + 4'd1;
                        col_x = {tab_grp, 3'b000};
                        if (col_x >= 7'(ttce_pkg::DISPLAY_COLS)) begin
                            col_x = '0;
                            row_x = row_x + 7'd1;
                        end
                    end
                    ttce_pkg::CH_BACKSPACE: begin
                        if (col_x != 7'd0) begin
                            col_x = col_x - 7'd1;
                        end
                    end
                    default: begin
                        wrote = 1'b1;
                        wline = (wsum >= 7'(ttce_pkg::BUFFER_ROWS))
                                ? 6'(wsum - 7'(ttce_pkg::BUFFER_ROWS)) : wsum[5:0];
                        wcol  = col_x;
                        col_x = col_x + 7'd1;
                        if (col_x >= 7'(ttce_pkg::DISPLAY_COLS)) begin
                            col_x = '0;
                            row_x = row_x + 7'd1;
                        end
                    end
                endcase

                // Running off the end of the ring recycles the oldest line.
                if (row_x >= 7'(ttce_pkg::BUFFER_ROWS)) begin
                    cleared  = 1'b1;
                    cline    = i_state.top;
                    top_n    = (i_state.top == 6'(ttce_pkg::BUFFER_ROWS - 1))
                               ? 6'd0 : i_state.top + 6'd1;
                    row_x    = 7'(ttce_pkg::BUFFER_ROWS - 1);
                    nxt.pend = 1'b1;
                end
                nxt.row = row_x[5:0];
                nxt.col = col_x;
                nxt.top = top_n;

                // At the end of a write the viewport follows the cursor.
                if (i_item.final_char) begin
                    redraw = nxt.pend;
                    if (row_x >= view_x + vis) begin
                        nxt.view = 6'(row_x - vis + 7'd1);
                        redraw   = 1'b1;
                    end else if (row_x < view_x) begin
                        nxt.view = row_x[5:0];
                        redraw   = 1'b1;
                    end
                    nxt.pend = 1'b0;
                end
            end
        endcase

        base               = '0;
        base.kind          = ttce_pkg::KIND_STATUS;
        base.cursor_row    = nxt.row;
        base.cursor_column = nxt.col;
        base.first_visible = nxt.view;
        base.top_line      = nxt.top;
        base.redraw        = redraw;
        base.last          = 1'b1;

        r1           = base;
        r1.kind      = ttce_pkg::KIND_CLEAR;
        r1.cell_line = cline;

        r0         = base;
        has_second = 1'b0;
        if (wrote) begin
            r0.kind        = ttce_pkg::KIND_WRITE;
            r0.cell_line   = wline;
            r0.cell_column = wcol;
            r0.cell_char   = i_item.char_code;
            r0.cell_attr   = i_text_attr;
            r0.last        = ~cleared;
            has_second     = cleared;
        end else if (cleared) begin
            r0 = r1;
        end
    end

    assign o_state          = nxt;
    assign o_out.first      = r0;
    assign o_out.second     = r1;
    assign o_out.has_second = has_second;

endmodule

// ===== hdl/ttce_out.sv =====
module ttce_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ttce_pkg::t_step_out  i_data,
    input  logic                 i_stall,
    output logic                 o_valid,
    output ttce_pkg::t_result    o_result,
    output logic                 o_can_push
);

    logic              r_out_valid;
    logic              r_ext_valid;
    ttce_pkg::t_result r_out;
    ttce_pkg::t_result r_ext;
    logic              take;

    assign take       = r_out_valid & ~i_stall;
    assign o_can_push = ~r_ext_valid & (~r_out_valid | ~i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ext_valid <= 1'b0;
        end else if (i_push) begin
            r_out_valid <= 1'b1;
            r_ext_valid <= i_data.has_second;
        end else if (take) begin
            r_out_valid <= r_ext_valid;
            r_ext_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_out <= i_data.first;
            r_ext <= i_data.second;
        end else if (take && r_ext_valid) begin
            r_out <= r_ext;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/text_terminal_cursor_engine.sv =====
// Cursor, viewport and scrollback ring control for a character-cell terminal.
// Input channel (i_in_valid / o_in_stall): one transaction per command, either
// put character, page up, page down or set cursor. Output channel
// (o_out_valid / i_out_stall): one or two result transactions per command,
// the last one flagged by o_last. A printable character that scrolls the
// ring gives a cell write followed by a line clear; everything else gives
// exactly one result.
// A command accepted into the input register is processed into the result
// register, which presents its first result. Throughput is one command per
// cycle while the output does not stall; a scrolling character occupies the
// output for both of its results, so the input sees stall behind it. The rate
// is set by the single step of cursor logic between the two registers.
// When the receiver stalls, the result register holds its transaction and the
// input register keeps one more command; further commands then see stall.
// The configuration port (i_cfg_valid / o_cfg_ready) is always ready and is
// meant to be written only while the block is idle.
// Reset clears the cursor, viewport, ring top and pending redraw, empties both
// channels, and loads the attribute with 7 and the header height with 1.
module text_terminal_cursor_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_char_code,
    input  logic        i_final_char,
    input  logic [6:0]  i_new_row,
    input  logic [7:0]  i_new_col,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [5:0]  o_cell_line,
    output logic [6:0]  o_cell_column,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attr,
    output logic [5:0]  o_cursor_row,
    output logic [6:0]  o_cursor_column,
    output logic [5:0]  o_first_visible,
    output logic [5:0]  o_top_line,
    output logic        o_redraw,
    output logic        o_last,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ttce_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ttce_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Input register: holds one command until the step logic can take it.
    logic             r_in_valid;
    ttce_pkg::t_item  r_in;

    // Configuration and terminal state.
    logic [ttce_pkg::ATTR_W-1:0] r_text_attr;
    logic [ttce_pkg::HDR_W-1:0]  r_header_lines;
    ttce_pkg::t_state            r_state;

    ttce_pkg::t_state    n_state;
    ttce_pkg::t_step_out step_out;
    ttce_pkg::t_result   out_result;
    logic                can_push;
    logic                proc;
    logic                in_accept;

    // The command in the input register moves on whenever the output
    // buffer has room for two results, as a scrolling character needs.
    assign proc       = r_in_valid & can_push;
    assign o_in_stall = r_in_valid & ~proc;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.op         <= ttce_pkg::t_op'(i_op);
            r_in.char_code  <= i_char_code;
            r_in.final_char <= i_final_char;
            r_in.new_row    <= i_new_row;
            r_in.new_col    <= i_new_col;
        end
    end

    // Register writes; an index outside the list is simply dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr    <= ttce_pkg::TEXT_ATTR_RESET;
            r_header_lines <= ttce_pkg::HEADER_LINES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ttce_pkg::CFG_TEXT_ATTR:    r_text_attr    <= i_cfg_data;
                ttce_pkg::CFG_HEADER_LINES: r_header_lines <= i_cfg_data[ttce_pkg::HDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    ttce_step u_step (
        .i_state        (r_state),
        .i_item         (r_in),
        .i_text_attr    (r_text_attr),
        .i_header_lines (r_header_lines),
        .o_state        (n_state),
        .o_out          (step_out)
    );

    ttce_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (proc),
        .i_data     (step_out),
        .i_stall    (i_out_stall),
        .o_valid    (o_out_valid),
        .o_result   (out_result),
        .o_can_push (can_push)
    );

    assign o_kind          = out_result.kind;
    assign o_cell_line     = out_result.cell_line;
    assign o_cell_column   = out_result.cell_column;
    assign o_cell_char     = out_result.cell_char;
    assign o_cell_attr     = out_result.cell_attr;
    assign o_cursor_row    = out_result.cursor_row;
    assign o_cursor_column = out_result.cursor_column;
    assign o_first_visible = out_result.first_visible;
    assign o_top_line      = out_result.top_line;
    assign o_redraw        = out_result.redraw;
    assign o_last          = out_result.last;

`ifndef ASSERT_OFF
    // A processed command always has a result waiting in the next cycle.
    a_proc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> o_out_valid)
        else $error("processed command produced no result");

    // The cursor column never leaves the screen width.
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.col < 7'(ttce_pkg::DISPLAY_COLS))
        else $error("cursor column out of range");

    // The only second result of a command is the line clear after a write.
    a_second_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last
        |=> o_out_valid && o_kind == ttce_pkg::KIND_CLEAR && o_last)
        else $error("non-final result not followed by a line clear");
`endif

endmodule
